// ----- rtl/core/ffbp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffbp_pkg
// Shared constants, request codes and controller/datapath bundles for the
// fixed-size block pool allocator.
// ----------------------------------------------------------------------------
package ffbp_pkg;

   localparam int unsigned CHUNK_SLOTS_DEF  = 1024;
   localparam int unsigned MAX_CHUNKS_DEF   = 4;
   localparam int unsigned HEADER_BYTES_DEF = 12;

   localparam int unsigned INDEX_SPACE = 4096;
   localparam int unsigned IDX_W       = 12;
   localparam int unsigned REQ_W       = 2;
   localparam int unsigned OFF_W       = 24;
   localparam int unsigned PB_W        = 12;
   localparam int unsigned SIZE_W      = 13;
   localparam int unsigned COUNT_W     = 13;
   localparam int unsigned PROD_W      = 25;
   localparam int unsigned DIV_CNT_W   = 5;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] CSR_PAYLOAD_BYTES_IDX = '0;
   localparam logic [PB_W-1:0] PAYLOAD_BYTES_RESET = 12'd64;

   typedef enum logic [REQ_W-1:0] {
      REQ_ALLOC = 2'd0,
      REQ_FREE  = 2'd1,
      REQ_CHECK = 2'd2,
      REQ_NONE  = 2'd3
   } req_kind_type;

   typedef struct packed {
      logic load;
      logic alloc_step;
      logic mul_step;
      logic free_step;
      logic div_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      req_kind_type kind;
      logic         div_last;
      logic         out_free;
   } sts_type;

endpackage
`default_nettype wire

// ----- rtl/core/ffbp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffbp_if
// Valid/ready channels for requests and responses of the block pool.
// ----------------------------------------------------------------------------
interface ffbp_req_if;
   import ffbp_pkg::*;

   logic               valid;
   logic               ready;
   logic [REQ_W-1:0]   req_type;
   logic [IDX_W-1:0]   slot_index;
   logic [OFF_W-1:0]   byte_offset;

   modport source (output valid, req_type, slot_index, byte_offset, input ready);
   modport sink   (input valid, req_type, slot_index, byte_offset, output ready);
endinterface

interface ffbp_rsp_if;
   import ffbp_pkg::*;

   logic               valid;
   logic               ready;
   logic               status;
   logic [IDX_W-1:0]   granted_index;
   logic [OFF_W-1:0]   payload_offset;
   logic               pointer_valid;
   logic [COUNT_W-1:0] slots_in_use;

   modport source (output valid, status, granted_index, payload_offset, pointer_valid,
                   slots_in_use, input ready);
   modport sink   (input valid, status, granted_index, payload_offset, pointer_valid,
                   slots_in_use, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/fifo_free_list_block_pool_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fifo_free_list_block_pool_core
// Fixed-size slot pool allocator with a FIFO free list and an APB-style
// register port for the payload size.
// ----------------------------------------------------------------------------
// One transaction is processed at a time and every transaction returns one
// response. Allocate goes through an allocation step, a link memory read
// with the offset multiply, and the response; free does at most one link
// memory write before its response, and no-op goes straight to the response.
// A pointer check divides the offset by the slot size in a restoring divider
// that produces one quotient bit per cycle over 24 bits. A finished response
// sits in an output register, so a new transaction is accepted while it
// waits. The payload_bytes register sits at byte address 0 and should only
// be written while no transaction is in flight.
module fifo_free_list_block_pool_core #(
   parameter int unsigned CHUNK_SLOTS  = ffbp_pkg::CHUNK_SLOTS_DEF,
   parameter int unsigned MAX_CHUNKS   = ffbp_pkg::MAX_CHUNKS_DEF,
   parameter int unsigned HEADER_BYTES = ffbp_pkg::HEADER_BYTES_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   ffbp_req_if.sink                              req_chan,
   ffbp_rsp_if.source                            rsp_chan,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [ffbp_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [ffbp_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output      logic [ffbp_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output      logic                             csr_pready
);
   import ffbp_pkg::*;

   logic [PB_W-1:0] payload_bytes_ff, payload_bytes_in;
   logic            csr_hit;
   cmd_type         cmd;
   sts_type         sts;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CSR_ADDR_W-1:2] == CSR_PAYLOAD_BYTES_IDX);

   always_comb begin
      payload_bytes_in = payload_bytes_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_hit) begin
         payload_bytes_in = csr_pwdata[PB_W-1:0];
      end
      csr_prdata = csr_hit ? CSR_DATA_W'(payload_bytes_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         payload_bytes_ff <= PAYLOAD_BYTES_RESET;
      end else begin
         payload_bytes_ff <= payload_bytes_in;
      end
   end

   ffbp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ffbp_dp #(
      .CHUNK_SLOTS  (CHUNK_SLOTS),
      .MAX_CHUNKS   (MAX_CHUNKS),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_type       (req_chan.req_type),
      .slot_index     (req_chan.slot_index),
      .byte_offset    (req_chan.byte_offset),
      .payload_bytes  (payload_bytes_ff),
      .rsp_ready      (rsp_chan.ready),
      .rsp_valid      (rsp_chan.valid),
      .status         (rsp_chan.status),
      .granted_index  (rsp_chan.granted_index),
      .payload_offset (rsp_chan.payload_offset),
      .pointer_valid  (rsp_chan.pointer_valid),
      .slots_in_use   (rsp_chan.slots_in_use)
   );

endmodule
`default_nettype wire

// ----- rtl/core/ffbp_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffbp_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ffbp_ram #(
   parameter int unsigned WIDTH = 12,
   parameter int unsigned DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- rtl/core/ffbp_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffbp_ctrl
// Sequencer of the block pool: takes one transaction, steps the datapath
// through it and hands the result to the output register.
// ----------------------------------------------------------------------------
module ffbp_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire ffbp_pkg::sts_type sts,
   output      ffbp_pkg::cmd_type cmd
);
   import ffbp_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_ALLOC = 6'b000010,
      S_MUL   = 6'b000100,
      S_FREE  = 6'b001000,
      S_DIV   = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               unique case (sts.kind)
                  REQ_ALLOC: state_in = S_ALLOC;
                  REQ_FREE:  state_in = S_FREE;
                  REQ_CHECK: state_in = S_DIV;
                  default:   state_in = S_DONE;
               endcase
            end
         end
         S_ALLOC: begin
            cmd.alloc_step = 1'b1;
            state_in       = S_MUL;
         end
         S_MUL: begin
            cmd.mul_step = 1'b1;
            state_in     = S_DONE;
         end
         S_FREE: begin
            cmd.free_step = 1'b1;
            state_in      = S_DONE;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // Wait until the previous response has been taken.
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/core/ffbp_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffbp_dp
// Datapath of the block pool: free list pointers, chunk bookkeeping, link
// memory, offset multiplier, bit-serial divider and the response register.
// ----------------------------------------------------------------------------
module ffbp_dp #(
   parameter int unsigned CHUNK_SLOTS  = ffbp_pkg::CHUNK_SLOTS_DEF,
   parameter int unsigned MAX_CHUNKS   = ffbp_pkg::MAX_CHUNKS_DEF,
   parameter int unsigned HEADER_BYTES = ffbp_pkg::HEADER_BYTES_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ffbp_pkg::cmd_type             cmd,
   output      ffbp_pkg::sts_type             sts,
   input  wire logic [ffbp_pkg::REQ_W-1:0]    req_type,
   input  wire logic [ffbp_pkg::IDX_W-1:0]    slot_index,
   input  wire logic [ffbp_pkg::OFF_W-1:0]    byte_offset,
   input  wire logic [ffbp_pkg::PB_W-1:0]     payload_bytes,
   input  wire logic                          rsp_ready,
   output      logic                          rsp_valid,
   output      logic                          status,
   output      logic [ffbp_pkg::IDX_W-1:0]    granted_index,
   output      logic [ffbp_pkg::OFF_W-1:0]    payload_offset,
   output      logic                          pointer_valid,
   output      logic [ffbp_pkg::COUNT_W-1:0]  slots_in_use
);
   import ffbp_pkg::*;

   // Number of slots once every chunk that fits the index space is open.
   localparam int unsigned CAP_CHUNKS =
      (MAX_CHUNKS * CHUNK_SLOTS > INDEX_SPACE) ? (INDEX_SPACE / CHUNK_SLOTS) : MAX_CHUNKS;
   localparam logic [COUNT_W-1:0] OPEN_LIMIT = COUNT_W'(CAP_CHUNKS * CHUNK_SLOTS);
   localparam logic [COUNT_W-1:0] CHUNK_STEP = COUNT_W'(CHUNK_SLOTS);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(OFF_W - 1);

   logic [SIZE_W-1:0] sum_w;
   logic [SIZE_W-1:0] size_w;

   req_kind_type       kind_ff, kind_in;
   logic [IDX_W-1:0]   slot_ff, slot_in;
   logic [IDX_W-1:0]   head_ff, head_in;
   logic [IDX_W-1:0]   tail_ff, tail_in;
   logic               empty_ff, empty_in;
   logic [COUNT_W-1:0] fresh_ff, fresh_in;
   logic [COUNT_W-1:0] opened_ff, opened_in;
   logic [COUNT_W-1:0] in_use_ff, in_use_in;
   logic [IDX_W-1:0]   grant_ff, grant_in;
   logic               fail_ff, fail_in;
   logic               pop_ff, pop_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [SIZE_W-1:0]  rem_ff, rem_in;
   logic [OFF_W-1:0]   dvd_ff, dvd_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic               hdr_ok_ff, hdr_ok_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               status_ff, status_in;
   logic [IDX_W-1:0]   granted_ff, granted_in;
   logic [OFF_W-1:0]   poff_ff, poff_in;
   logic               ptr_valid_ff, ptr_valid_in;
   logic [COUNT_W-1:0] use_out_ff, use_out_in;

   logic [SIZE_W:0]    trial;
   logic               qbit;
   logic               ok_alloc;

   logic               ram_wr_en;
   logic [IDX_W-1:0]   ram_wr_addr;
   logic [IDX_W-1:0]   ram_wr_data;
   logic               ram_rd_en;
   logic [IDX_W-1:0]   ram_rd_data;

   // Slot size: payload plus header, then always bumped to the next multiple of 4.
   assign sum_w  = SIZE_W'(payload_bytes) + SIZE_W'(HEADER_BYTES);
   assign size_w = {sum_w[SIZE_W-1:2], 2'b00} + SIZE_W'(4);

   assign ram_wr_addr = tail_ff;
   assign ram_wr_data = slot_ff;

   ffbp_ram #(
      .WIDTH (IDX_W),
      .DEPTH (INDEX_SPACE)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (head_ff),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      kind_in   = kind_ff;
      slot_in   = slot_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      empty_in  = empty_ff;
      fresh_in  = fresh_ff;
      opened_in = opened_ff;
      in_use_in = in_use_ff;
      grant_in  = grant_ff;
      fail_in   = fail_ff;
      pop_in    = pop_ff;
      prod_in   = prod_ff;
      rem_in    = rem_ff;
      dvd_in    = dvd_ff;
      cnt_in    = cnt_ff;
      hdr_ok_in = hdr_ok_ff;
      ram_wr_en = 1'b0;
      ram_rd_en = 1'b0;
      trial     = {rem_ff, dvd_ff[OFF_W-1]};
      qbit      = 1'b0;
      ok_alloc  = (kind_ff == REQ_ALLOC) && !fail_ff;

      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      granted_in   = granted_ff;
      poff_in      = poff_ff;
      ptr_valid_in = ptr_valid_ff;
      use_out_in   = use_out_ff;

      if (cmd.load) begin
         kind_in   = req_kind_type'(req_type);
         slot_in   = slot_index;
         hdr_ok_in = byte_offset >= OFF_W'(HEADER_BYTES);
         dvd_in    = byte_offset - OFF_W'(HEADER_BYTES);
         rem_in    = '0;
         cnt_in    = '0;
         fail_in   = 1'b0;
         grant_in  = '0;
         pop_in    = 1'b0;
      end

      if (cmd.alloc_step) begin
         // The head's successor is fetched now and used in the multiply step.
         ram_rd_en = 1'b1;
         if (fresh_ff < opened_ff) begin
            grant_in = fresh_ff[IDX_W-1:0];
            fresh_in = fresh_ff + COUNT_W'(1);
         end else if (!empty_ff) begin
            grant_in = head_ff;
            if (head_ff == tail_ff) begin
               empty_in = 1'b1;
            end else begin
               pop_in = 1'b1;
            end
         end else if (opened_ff < OPEN_LIMIT) begin
            grant_in  = opened_ff[IDX_W-1:0];
            opened_in = opened_ff + CHUNK_STEP;
            fresh_in  = opened_ff + COUNT_W'(1);
         end else begin
            fail_in = 1'b1;
         end
         if (!fail_in) begin
            in_use_in = in_use_ff + COUNT_W'(1);
         end
      end

      if (cmd.mul_step) begin
         prod_in = PROD_W'(grant_ff) * PROD_W'(size_w);
         if (pop_ff) begin
            head_in = ram_rd_data;
            pop_in  = 1'b0;
         end
      end

      if (cmd.free_step) begin
         if ({1'b0, slot_ff} < opened_ff) begin
            if (empty_ff) begin
               head_in  = slot_ff;
               empty_in = 1'b0;
            end else begin
               ram_wr_en = 1'b1;
            end
            tail_in   = slot_ff;
            in_use_in = in_use_ff - COUNT_W'(1);
         end
      end

      if (cmd.div_step) begin
         // Restoring division, one quotient bit per cycle; the quotient
         // shifts into the dividend register as the dividend shifts out.
         if (trial >= {1'b0, size_w}) begin
            rem_in = SIZE_W'(trial - {1'b0, size_w});
            qbit   = 1'b1;
         end else begin
            rem_in = trial[SIZE_W-1:0];
         end
         dvd_in = {dvd_ff[OFF_W-2:0], qbit};
         cnt_in = cnt_ff + DIV_CNT_W'(1);
      end

      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         status_in    = (kind_ff == REQ_ALLOC) && fail_ff;
         granted_in   = ok_alloc ? grant_ff : '0;
         poff_in      = ok_alloc ? OFF_W'(prod_ff + PROD_W'(HEADER_BYTES)) : '0;
         // Valid for an exact quotient past the header that names an opened slot.
         ptr_valid_in = (kind_ff == REQ_CHECK) && hdr_ok_ff && (rem_ff == '0)
                        && (dvd_ff < OFF_W'(opened_ff));
         use_out_in   = in_use_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         empty_ff     <= 1'b1;
         fresh_ff     <= '0;
         opened_ff    <= CHUNK_STEP;
         in_use_ff    <= '0;
         pop_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         empty_ff     <= empty_in;
         fresh_ff     <= fresh_in;
         opened_ff    <= opened_in;
         in_use_ff    <= in_use_in;
         pop_ff       <= pop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      slot_ff      <= slot_in;
      grant_ff     <= grant_in;
      fail_ff      <= fail_in;
      prod_ff      <= prod_in;
      rem_ff       <= rem_in;
      dvd_ff       <= dvd_in;
      cnt_ff       <= cnt_in;
      hdr_ok_ff    <= hdr_ok_in;
      status_ff    <= status_in;
      granted_ff   <= granted_in;
      poff_ff      <= poff_in;
      ptr_valid_ff <= ptr_valid_in;
      use_out_ff   <= use_out_in;
   end

   assign sts.kind     = req_kind_type'(req_type);
   assign sts.div_last = (cnt_ff == DIV_LAST);
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign status         = status_ff;
   assign granted_index  = granted_ff;
   assign payload_offset = poff_ff;
   assign pointer_valid  = ptr_valid_ff;
   assign slots_in_use   = use_out_ff;

endmodule
`default_nettype wire
